### rtl/matrix_vector_multiply_assert.svh
// Assertion macros for the matrix-vector multiply checker.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef MATRIX_VECTOR_MULTIPLY_ASSERT_SVH
`define MATRIX_VECTOR_MULTIPLY_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MVM_ASSERT_SAME(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define MVM_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/mvm_pkg.sv
// Shared types and constants for the matrix-vector multiply block.
// Depends on nothing; used by every module of the block except mvm_ram.
package mvm_pkg;

    localparam int VALUE_BITS = 16;
    localparam int FRAC_BITS  = 8;
    localparam int PROD_BITS  = 2 * VALUE_BITS;
    localparam int ACC_BITS   = 48;
    localparam int SUM_BITS   = 32;
    localparam int INDEX_BITS = 12;
    localparam int VLEN_BITS  = 11;
    localparam int RCNT_BITS  = 13;
    localparam int PADDR_BITS = 3;
    localparam int PDATA_BITS = 32;

    localparam logic [PADDR_BITS-1:0] ADDR_VECTOR_LENGTH = 3'd0;
    localparam logic [PADDR_BITS-1:0] ADDR_ROW_COUNT     = 3'd4;

    localparam logic [VLEN_BITS-1:0] VLEN_RESET = 11'd1024;
    localparam logic [RCNT_BITS-1:0] RCNT_RESET = 13'd4096;

    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_WEIGHT = 1'b1;

    localparam logic signed [ACC_BITS:0] RND_HALF =
        ({{ACC_BITS{1'b0}}, 1'b1} << FRAC_BITS) >> 1;
    localparam logic signed [ACC_BITS:0] SAT_MAX =
        {{(ACC_BITS - SUM_BITS + 2){1'b0}}, {(SUM_BITS - 1){1'b1}}};
    localparam logic signed [ACC_BITS:0] SAT_MIN =
        {{(ACC_BITS - SUM_BITS + 2){1'b1}}, {(SUM_BITS - 1){1'b0}}};

    typedef struct packed {
        logic                          kind;
        logic signed [VALUE_BITS-1:0]  value;
    } t_in_item;

    typedef struct packed {
        logic signed [SUM_BITS-1:0]    row_sum;
        logic        [INDEX_BITS-1:0]  row_index;
        logic                          last_row;
    } t_out_item;

    typedef enum logic {
        ST_ROW_START,
        ST_ROW_BUSY
    } t_state;

    typedef struct packed {
        logic adv;
        logic mem_wr;
        logic mem_rd;
        logic acc_en;
        logic acc_first;
        logic out_ld;
        logic row_last;
    } t_dp_cmd;

endpackage

### rtl/mvm_ram.sv
// Generic single-port RAM with a registered read port.
// Depends on nothing.
module mvm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic             i_we,
    input  logic [AW-1:0]    i_addr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/mvm_ctrl.sv
// Controller: position counters, row state machine and pipeline valid tracking.
// Depends on mvm_pkg; drives the command bundle of mvm_dp.
module mvm_ctrl #(
    parameter int MAX_COLUMNS = 1024,
    parameter int MAX_ROWS    = 4096,
    localparam int AW  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1,
    localparam int CW  = $clog2(MAX_COLUMNS + 1),
    localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
    localparam int RCW = $clog2(MAX_ROWS + 1)
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    input  logic                               i_kind,
    input  logic [mvm_pkg::VLEN_BITS-1:0]      i_vector_length,
    input  logic [mvm_pkg::RCNT_BITS-1:0]      i_row_count,
    input  logic                               i_stall,
    output logic                               o_stall,
    output logic                               o_valid,
    output mvm_pkg::t_dp_cmd                   o_cmd,
    output logic [AW-1:0]                      o_mem_addr,
    output logic [mvm_pkg::INDEX_BITS-1:0]     o_row_index
);

    mvm_pkg::t_state r_state, n_state;
    logic [AW-1:0]   r_load_pos, n_load_pos;
    logic [AW-1:0]   r_col_pos, n_col_pos;
    logic [RW-1:0]   r_row_pos, n_row_pos;
    logic            r_v1, r_e1, r_f1;
    logic            r_v2, r_e2, r_f2;
    logic            r_v3, r_e3;
    logic            r_out_valid;

    logic [CW-1:0]   cols_eff;
    logic [RCW-1:0]  rows_eff;
    logic [AW-1:0]   load_pos, col_pos;
    logic [CW-1:0]   load_inc, col_inc;
    logic [RCW-1:0]  row_inc;
    logic            row_end, row_last, row_first;
    logic            adv, accept, load_acc, wt_acc;

    always_comb begin
        if (i_vector_length == '0) begin
            cols_eff = CW'(1);
        end else if (32'(i_vector_length) > 32'(MAX_COLUMNS)) begin
            cols_eff = CW'(MAX_COLUMNS);
        end else begin
            cols_eff = CW'(i_vector_length);
        end
        if (i_row_count == '0) begin
            rows_eff = RCW'(1);
        end else if (32'(i_row_count) > 32'(MAX_ROWS)) begin
            rows_eff = RCW'(MAX_ROWS);
        end else begin
            rows_eff = RCW'(i_row_count);
        end
    end

    assign adv      = !(r_out_valid && i_stall);
    assign accept   = i_valid && adv;
    assign load_acc = accept && (i_kind == mvm_pkg::KIND_LOAD);
    assign wt_acc   = accept && (i_kind == mvm_pkg::KIND_WEIGHT);

    always_comb begin
        load_pos = (CW'(r_load_pos) >= cols_eff) ? '0 : r_load_pos;
        load_inc = CW'(load_pos) + CW'(1);
        col_pos  = (CW'(r_col_pos) >= cols_eff) ? AW'(cols_eff - CW'(1)) : r_col_pos;
        col_inc  = CW'(col_pos) + CW'(1);
        row_end  = (col_inc >= cols_eff);
        row_inc  = RCW'(r_row_pos) + RCW'(1);
        row_last = (row_inc >= rows_eff);

        n_load_pos = r_load_pos;
        n_col_pos  = r_col_pos;
        n_row_pos  = r_row_pos;
        if (load_acc) begin
            n_load_pos = (load_inc >= cols_eff) ? '0 : AW'(load_inc);
        end
        if (wt_acc) begin
            n_col_pos = row_end ? '0 : AW'(col_inc);
            if (row_end) begin
                n_row_pos = row_last ? '0 : RW'(row_inc);
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            mvm_pkg::ST_ROW_START: begin
                if (wt_acc && !row_end) begin
                    n_state = mvm_pkg::ST_ROW_BUSY;
                end
            end
            mvm_pkg::ST_ROW_BUSY: begin
                if (wt_acc && row_end) begin
                    n_state = mvm_pkg::ST_ROW_START;
                end
            end
            default: begin
                n_state = mvm_pkg::ST_ROW_START;
            end
        endcase
    end

    always_comb begin
        case (r_state)
            mvm_pkg::ST_ROW_START: begin
                row_first = 1'b1;
            end
            mvm_pkg::ST_ROW_BUSY: begin
                row_first = 1'b0;
            end
            default: begin
                row_first = 1'b1;
            end
        endcase
        o_cmd.adv       = adv;
        o_cmd.mem_wr    = load_acc;
        o_cmd.mem_rd    = wt_acc;
        o_cmd.acc_en    = r_v2 && adv;
        o_cmd.acc_first = r_f2;
        o_cmd.out_ld    = r_v3 && r_e3 && adv;
        o_cmd.row_last  = row_last;
        o_mem_addr      = (i_kind == mvm_pkg::KIND_LOAD) ? load_pos : col_pos;
        o_row_index     = mvm_pkg::INDEX_BITS'(r_row_pos);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mvm_pkg::ST_ROW_START;
            r_load_pos  <= '0;
            r_col_pos   <= '0;
            r_row_pos   <= '0;
            r_v1        <= 1'b0;
            r_e1        <= 1'b0;
            r_f1        <= 1'b0;
            r_v2        <= 1'b0;
            r_e2        <= 1'b0;
            r_f2        <= 1'b0;
            r_v3        <= 1'b0;
            r_e3        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_load_pos <= n_load_pos;
            r_col_pos  <= n_col_pos;
            r_row_pos  <= n_row_pos;
            if (adv) begin
                r_v1        <= wt_acc;
                r_e1        <= row_end;
                r_f1        <= row_first;
                r_v2        <= r_v1;
                r_e2        <= r_e1;
                r_f2        <= r_f1;
                r_v3        <= r_v2;
                r_e3        <= r_e2;
                r_out_valid <= r_v3 && r_e3;
            end
        end
    end

    assign o_stall = !adv;
    assign o_valid = r_out_valid;

endmodule

### rtl/mvm_dp.sv
// Datapath: vector store, multiplier, accumulator, rounding and output register.
// Depends on mvm_pkg and mvm_ram; steered by the command bundle of mvm_ctrl.
module mvm_dp #(
    parameter int MAX_COLUMNS = 1024,
    localparam int AW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1
) (
    input  logic                           i_clk,
    input  mvm_pkg::t_in_item              i_data,
    input  mvm_pkg::t_dp_cmd               i_cmd,
    input  logic [AW-1:0]                  i_mem_addr,
    input  logic [mvm_pkg::INDEX_BITS-1:0] i_row_index,
    output mvm_pkg::t_out_item             o_data
);

    logic [mvm_pkg::VALUE_BITS-1:0]        ram_rdata;
    logic signed [mvm_pkg::VALUE_BITS-1:0] r_s1_weight;
    logic [mvm_pkg::INDEX_BITS-1:0]        r_s1_index, r_s2_index, r_s3_index;
    logic                                  r_s1_last, r_s2_last, r_s3_last;
    logic signed [mvm_pkg::PROD_BITS-1:0]  r_s2_prod;
    logic [mvm_pkg::ACC_BITS-1:0]          r_acc;
    logic [mvm_pkg::ACC_BITS-1:0]          prod_ext;
    logic signed [mvm_pkg::ACC_BITS:0]     rnd_sum, rnd_q;
    logic signed [mvm_pkg::SUM_BITS-1:0]   sat_sum;
    mvm_pkg::t_out_item                    r_out;

    mvm_ram #(
        .WIDTH (mvm_pkg::VALUE_BITS),
        .DEPTH (MAX_COLUMNS)
    ) u_vector_store (
        .i_clk   (i_clk),
        .i_en    (i_cmd.mem_wr || i_cmd.mem_rd),
        .i_we    (i_cmd.mem_wr),
        .i_addr  (i_mem_addr),
        .i_wdata (i_data.value),
        .o_rdata (ram_rdata)
    );

    assign prod_ext = mvm_pkg::ACC_BITS'(r_s2_prod);

    always_comb begin
        rnd_sum = $signed({r_acc[mvm_pkg::ACC_BITS-1], r_acc}) + mvm_pkg::RND_HALF;
        rnd_q   = rnd_sum >>> mvm_pkg::FRAC_BITS;
        if (rnd_q > mvm_pkg::SAT_MAX) begin
            sat_sum = mvm_pkg::SAT_MAX[mvm_pkg::SUM_BITS-1:0];
        end else if (rnd_q < mvm_pkg::SAT_MIN) begin
            sat_sum = mvm_pkg::SAT_MIN[mvm_pkg::SUM_BITS-1:0];
        end else begin
            sat_sum = rnd_q[mvm_pkg::SUM_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.adv) begin
            r_s1_weight <= i_data.value;
            r_s1_index  <= i_row_index;
            r_s1_last   <= i_cmd.row_last;
            r_s2_prod   <= r_s1_weight * $signed(ram_rdata);
            r_s2_index  <= r_s1_index;
            r_s2_last   <= r_s1_last;
            r_s3_index  <= r_s2_index;
            r_s3_last   <= r_s2_last;
        end
        if (i_cmd.acc_en) begin
            r_acc <= i_cmd.acc_first ? prod_ext : r_acc + prod_ext;
        end
        if (i_cmd.out_ld) begin
            r_out.row_sum   <= sat_sum;
            r_out.row_index <= r_s3_index;
            r_out.last_row  <= r_s3_last;
        end
    end

    assign o_data = r_out;

endmodule

### rtl/matrix_vector_multiply.sv
// Matrix-vector multiply: one item per cycle while not stalled; a row sum appears once the
// row's last weight has passed the store read, multiply, accumulate and output stages.
// The pipeline only stops while a finished sum waits in the output register.
// Reset is synchronous and active low: counters, pipeline and row state clear, the
// registers return to 1024 columns and 4096 rows; the vector store is not cleared.
module matrix_vector_multiply #(
    parameter int MAX_COLUMNS = 1024,
    parameter int MAX_ROWS    = 4096
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  mvm_pkg::t_in_item                  i_data,
    output logic                               o_valid,
    input  logic                               i_stall,
    output mvm_pkg::t_out_item                 o_data,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [mvm_pkg::PADDR_BITS-1:0]     paddr,
    input  logic [mvm_pkg::PDATA_BITS-1:0]     pwdata,
    output logic [mvm_pkg::PDATA_BITS-1:0]     prdata,
    output logic                               pready
);

    localparam int AW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

    logic [mvm_pkg::VLEN_BITS-1:0]  r_vector_length;
    logic [mvm_pkg::RCNT_BITS-1:0]  r_row_count;
    logic                           cfg_wr;
    mvm_pkg::t_dp_cmd               dp_cmd;
    logic [AW-1:0]                  mem_addr;
    logic [mvm_pkg::INDEX_BITS-1:0] row_index;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vector_length <= mvm_pkg::VLEN_RESET;
            r_row_count     <= mvm_pkg::RCNT_RESET;
        end else if (cfg_wr) begin
            case (paddr)
                mvm_pkg::ADDR_VECTOR_LENGTH: begin
                    r_vector_length <= pwdata[mvm_pkg::VLEN_BITS-1:0];
                end
                mvm_pkg::ADDR_ROW_COUNT: begin
                    r_row_count <= pwdata[mvm_pkg::RCNT_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr)
            mvm_pkg::ADDR_VECTOR_LENGTH: begin
                prdata = mvm_pkg::PDATA_BITS'(r_vector_length);
            end
            mvm_pkg::ADDR_ROW_COUNT: begin
                prdata = mvm_pkg::PDATA_BITS'(r_row_count);
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    mvm_ctrl #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .i_kind          (i_data.kind),
        .i_vector_length (r_vector_length),
        .i_row_count     (r_row_count),
        .i_stall         (i_stall),
        .o_stall         (o_stall),
        .o_valid         (o_valid),
        .o_cmd           (dp_cmd),
        .o_mem_addr      (mem_addr),
        .o_row_index     (row_index)
    );

    mvm_dp #(
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_data      (i_data),
        .i_cmd       (dp_cmd),
        .i_mem_addr  (mem_addr),
        .i_row_index (row_index),
        .o_data      (o_data)
    );

endmodule

### rtl/mvm_checker.sv
// Port-level checker for the matrix-vector multiply, bound to the top level.
// Depends on mvm_pkg and matrix_vector_multiply_assert.svh.
`include "matrix_vector_multiply_assert.svh"

module mvm_port_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_stall,
    input mvm_pkg::t_in_item  i_data,
    input logic               o_valid,
    input logic               i_stall,
    input mvm_pkg::t_out_item o_data
);

    `MVM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_data))
    `MVM_ASSERT_SAME(a_empty_no_stall, i_clk, i_rst_n, !o_valid, !o_stall)
    `MVM_ASSERT_SAME(a_stall_follows_out, i_clk, i_rst_n, o_valid && i_stall, o_stall)
    `MVM_ASSERT_SAME(a_drain_frees_in, i_clk, i_rst_n, o_valid && !i_stall, !o_stall)
    `MVM_ASSERT_SAME(a_reset_empty, i_clk, i_rst_n, $past(!i_rst_n), !o_valid)

endmodule

bind matrix_vector_multiply mvm_port_checker u_checker (.*);

### sim/mvm_checker.sv
// Checker for the matrix-vector multiply block: watches both channels and the register port,
// predicts every row sum and compares each output transfer with the oldest one due.
// Depends on mvm_pkg for the payload types, the field widths and the register addresses.
module mvm_checker #(
    parameter int MAX_COLUMNS = 1024,
    parameter int MAX_ROWS    = 4096
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_stall,
    input  mvm_pkg::t_in_item               i_in_data,
    input  logic                            i_out_valid,
    input  logic                            i_out_stall,
    input  mvm_pkg::t_out_item              i_out_data,
    input  logic                            i_psel,
    input  logic                            i_penable,
    input  logic                            i_pwrite,
    input  logic                            i_pready,
    input  logic [mvm_pkg::PADDR_BITS-1:0]  i_paddr,
    input  logic [mvm_pkg::PDATA_BITS-1:0]  i_pwdata,
    output int                              o_errors,
    output int                              o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic signed [mvm_pkg::VALUE_BITS-1:0] vec_mem [MAX_COLUMNS];
    int unsigned                           load_pos;
    int unsigned                           col_pos;
    int unsigned                           row_pos;
    logic [mvm_pkg::ACC_BITS-1:0]          acc;
    logic [mvm_pkg::VLEN_BITS-1:0]         cfg_vlen;
    logic [mvm_pkg::RCNT_BITS-1:0]         cfg_rcnt;
    mvm_pkg::t_out_item                    sums_due [$];
    int                                    mismatches;

    function automatic logic signed [mvm_pkg::SUM_BITS-1:0] round_saturate(
        input logic signed [mvm_pkg::ACC_BITS-1:0] total
    );
        longint sat_hi;
        longint sat_lo;
        longint r;
        sat_hi = (longint'(1) << (mvm_pkg::SUM_BITS - 1)) - 1;
        sat_lo = -(longint'(1) << (mvm_pkg::SUM_BITS - 1));
        r = longint'(total) + ((longint'(1) << mvm_pkg::FRAC_BITS) >>> 1);
        r = r >>> mvm_pkg::FRAC_BITS;
        if (r > sat_hi) begin
            r = sat_hi;
        end else if (r < sat_lo) begin
            r = sat_lo;
        end
        return r[mvm_pkg::SUM_BITS-1:0];
    endfunction

    task automatic predict_row_sum(input mvm_pkg::t_in_item item);
        int unsigned        n;
        int unsigned        d;
        longint             prod;
        logic               is_last;
        mvm_pkg::t_out_item sum;
        n = (cfg_vlen == 0) ? 1 : ((cfg_vlen > MAX_COLUMNS) ? MAX_COLUMNS : cfg_vlen);
        d = (cfg_rcnt == 0) ? 1 : ((cfg_rcnt > MAX_ROWS) ? MAX_ROWS : cfg_rcnt);
        if (item.kind == mvm_pkg::KIND_LOAD) begin
            if (load_pos >= n) begin
                load_pos = 0;
            end
            vec_mem[load_pos % MAX_COLUMNS] = item.value;
            load_pos = (load_pos + 1 >= n) ? 0 : load_pos + 1;
        end else begin
            if (col_pos >= n) begin
                col_pos = n - 1;
            end
            prod = longint'($signed(item.value)) * longint'(vec_mem[col_pos % MAX_COLUMNS]);
            acc = acc + prod[mvm_pkg::ACC_BITS-1:0];
            if (col_pos + 1 < n) begin
                col_pos++;
            end else begin
                is_last       = (row_pos + 1 >= d);
                sum.row_sum   = round_saturate($signed(acc));
                sum.row_index = row_pos[mvm_pkg::INDEX_BITS-1:0];
                sum.last_row  = is_last;
                sums_due.push_back(sum);
                acc     = '0;
                col_pos = 0;
                row_pos = is_last ? 0 : row_pos + 1;
            end
        end
    endtask

    task automatic compare_row_sum(input mvm_pkg::t_out_item got);
        mvm_pkg::t_out_item want;
        if (sums_due.size() == 0) begin
            $error("row_sum: none expected, got %0d for row %0d",
                   $signed(got.row_sum), got.row_index);
            mismatches++;
        end else begin
            want = sums_due.pop_front();
            if (got.row_sum !== want.row_sum) begin
                $error("row_sum: expected %0d, got %0d",
                       $signed(want.row_sum), $signed(got.row_sum));
                mismatches++;
            end
            if (got.row_index !== want.row_index) begin
                $error("row_index: expected %0d, got %0d", want.row_index, got.row_index);
                mismatches++;
            end
            if (got.last_row !== want.last_row) begin
                $error("last_row: expected %0b, got %0b", want.last_row, got.last_row);
                mismatches++;
            end
        end
    endtask

    initial begin
        mismatches = 0;
        o_errors   = 0;
        o_pending  = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            load_pos = 0;
            col_pos  = 0;
            row_pos  = 0;
            acc      = '0;
            cfg_vlen = mvm_pkg::VLEN_RESET;
            cfg_rcnt = mvm_pkg::RCNT_RESET;
            sums_due.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr)
                    mvm_pkg::ADDR_VECTOR_LENGTH: begin
                        cfg_vlen = i_pwdata[mvm_pkg::VLEN_BITS-1:0];
                    end
                    mvm_pkg::ADDR_ROW_COUNT: begin
                        cfg_rcnt = i_pwdata[mvm_pkg::RCNT_BITS-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                predict_row_sum(i_in_data);
            end
            if (i_out_valid && !i_out_stall) begin
                compare_row_sum(i_out_data);
            end
        end
        o_errors  = mismatches;
        o_pending = sums_due.size();
    end

endmodule

### sim/tb_top.sv
// Top of the matrix-vector multiply testbench: clock, reset, register writes and the
// input and output traffic, with the checker beside the block and the verdict at the end.
// Depends on mvm_pkg, matrix_vector_multiply and mvm_checker.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_COLUMNS   = 1024;
    localparam int MAX_ROWS      = 4096;
    localparam int IDLE_PCT      = 17;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 12;
    localparam int TOTAL_ITEMS   = 400;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_valid;
    logic                            o_stall;
    mvm_pkg::t_in_item               i_data;
    logic                            o_valid;
    logic                            i_stall;
    mvm_pkg::t_out_item              o_data;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [mvm_pkg::PADDR_BITS-1:0]  paddr;
    logic [mvm_pkg::PDATA_BITS-1:0]  pwdata;
    logic [mvm_pkg::PDATA_BITS-1:0]  prdata;
    logic                            pready;

    int                 errors;
    int                 pending;
    mvm_pkg::t_in_item  items_todo [$];
    int                 items_queued;
    logic               calm;
    logic               hold_req;
    logic               hold_done;
    int                 hold_count;

    matrix_vector_multiply #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    mvm_checker #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .i_in_stall  (o_stall),
        .i_in_data   (i_data),
        .i_out_valid (o_valid),
        .i_out_stall (i_stall),
        .i_out_data  (o_data),
        .i_psel      (psel),
        .i_penable   (penable),
        .i_pwrite    (pwrite),
        .i_pready    (pready),
        .i_paddr     (paddr),
        .i_pwdata    (pwdata),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || !o_stall) begin
            if (items_todo.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
                i_data  <= items_todo.pop_front();
                i_valid <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // The long hold-off lets the output register and the pipeline fill up.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_req && !hold_done) begin
            i_stall <= 1'b1;
            hold_count++;
            if (hold_count >= HOLD_CYCLES) begin
                hold_done = 1'b1;
            end
        end else begin
            i_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
        end
    end

    task automatic queue_item(input logic kind, input logic [mvm_pkg::VALUE_BITS-1:0] value);
        mvm_pkg::t_in_item item;
        item.kind  = kind;
        item.value = value;
        items_todo.push_back(item);
        items_queued++;
    endtask

    function automatic logic [mvm_pkg::VALUE_BITS-1:0] pick_value();
        case ($urandom_range(9))
            0: begin
                return 16'h7FFF;
            end
            1: begin
                return 16'h8000;
            end
            2: begin
                return 16'h0000;
            end
            3: begin
                return 16'hFFFF;
            end
            default: begin
                return mvm_pkg::VALUE_BITS'($urandom());
            end
        endcase
    endfunction

    task automatic load_vector(input int unsigned n);
        for (int i = 0; i < n; i++) begin
            queue_item(mvm_pkg::KIND_LOAD, pick_value());
        end
    endtask

    task automatic stream_weights(input int unsigned count);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(99) < 8) begin
                queue_item(mvm_pkg::KIND_LOAD, pick_value());
            end
            queue_item(mvm_pkg::KIND_WEIGHT, pick_value());
        end
    endtask

    task automatic wait_quiet();
        @(negedge i_clk);
        while (items_todo.size() != 0 || i_valid || pending != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic apb_write(input logic [mvm_pkg::PADDR_BITS-1:0] addr,
                             input logic [mvm_pkg::PDATA_BITS-1:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) begin
            @(posedge i_clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic configure(input logic [mvm_pkg::PDATA_BITS-1:0] vlen_word,
                             input logic [mvm_pkg::PDATA_BITS-1:0] rcnt_word);
        wait_quiet();
        apb_write(mvm_pkg::ADDR_VECTOR_LENGTH, vlen_word);
        apb_write(mvm_pkg::ADDR_ROW_COUNT, rcnt_word);
        @(negedge i_clk);
    endtask

    initial begin : stimulus
        int unsigned                    n;
        int unsigned                    rows;
        int unsigned                    partial;
        int                             phase_no;
        logic [mvm_pkg::PDATA_BITS-1:0] vlen_word;
        logic [mvm_pkg::PDATA_BITS-1:0] rcnt_word;

        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_data       = '0;
        i_stall      = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        calm         = 1'b0;
        hold_req     = 1'b0;
        hold_done    = 1'b0;
        hold_count   = 0;
        items_queued = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        configure(32'd2, 32'd3);
        queue_item(mvm_pkg::KIND_LOAD, 16'h7FFF);
        queue_item(mvm_pkg::KIND_LOAD, 16'h8000);
        queue_item(mvm_pkg::KIND_LOAD, 16'h0001);
        queue_item(mvm_pkg::KIND_WEIGHT, 16'h0080);
        queue_item(mvm_pkg::KIND_WEIGHT, 16'h0000);
        queue_item(mvm_pkg::KIND_WEIGHT, 16'hFF80);
        queue_item(mvm_pkg::KIND_WEIGHT, 16'h0000);
        queue_item(mvm_pkg::KIND_WEIGHT, 16'h7FFF);
        queue_item(mvm_pkg::KIND_WEIGHT, 16'h8000);
        queue_item(mvm_pkg::KIND_WEIGHT, 16'h8000);
        queue_item(mvm_pkg::KIND_WEIGHT, 16'h7FFF);

        configure(32'd1, 32'd0);
        queue_item(mvm_pkg::KIND_LOAD, 16'hFFFF);
        queue_item(mvm_pkg::KIND_WEIGHT, 16'h7FFF);
        queue_item(mvm_pkg::KIND_WEIGHT, 16'h8000);
        queue_item(mvm_pkg::KIND_WEIGHT, 16'h1234);

        configure(32'd0, 32'd1);
        queue_item(mvm_pkg::KIND_WEIGHT, 16'hFFFF);

        phase_no = 0;
        while (items_queued < TOTAL_ITEMS) begin
            case ($urandom_range(9))
                0: begin
                    vlen_word = 0;
                end
                1: begin
                    vlen_word = 1;
                end
                2: begin
                    vlen_word = 16;
                end
                default: begin
                    vlen_word = $urandom_range(2, 8);
                end
            endcase
            case ($urandom_range(7))
                0: begin
                    rcnt_word = 0;
                end
                1: begin
                    rcnt_word = 8191;
                end
                default: begin
                    rcnt_word = $urandom_range(1, 6);
                end
            endcase
            if (phase_no < 2) begin
                vlen_word = 6;
            end
            n = (vlen_word == 0) ? 1 : vlen_word;
            configure(($urandom() & 32'hFFFF_F800) | vlen_word,
                      ($urandom() & 32'hFFFF_E000) | rcnt_word);
            calm = (phase_no == 0);
            rows = (phase_no < 2) ? 16 : $urandom_range(2, 10);
            if (phase_no == 1) begin
                hold_req = 1'b1;
            end
            partial = ($urandom_range(2) == 0) ? $urandom_range(n - 1) : 0;
            load_vector(n);
            stream_weights(rows * n + partial);
            phase_no++;
        end

        wait_quiet();
        calm = 1'b0;
        repeat (20) @(negedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

    initial begin : watchdog
        #4_000_000;
        $display("tb_top NOT OK");
        $finish;
    end

endmodule

### sim.f
+incdir+rtl
rtl/mvm_pkg.sv
rtl/mvm_ram.sv
rtl/mvm_ctrl.sv
rtl/mvm_dp.sv
rtl/matrix_vector_multiply.sv
rtl/mvm_checker.sv
sim/mvm_checker.sv
sim/tb_top.sv
